>>> rtl/ttmt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tournament tree max tracker.
// No dependencies.
package ttmt_pkg;

	localparam int SLOT_COUNT_DEF = 1024;
	localparam int DIFF_WIDTH     = 8;
	localparam int BLOCK_WIDTH    = 48;
	localparam int SIZE_WIDTH     = 7;
	localparam int COUNT_WIDTH    = 16;
	localparam int SPAN_WIDTH     = SIZE_WIDTH + COUNT_WIDTH;
	localparam int STEP_WIDTH     = 6;
	localparam int ROW_WIDTH      = 4 * DIFF_WIDTH;

	localparam logic [STEP_WIDTH-1:0] DIV_STEPS = STEP_WIDTH'(BLOCK_WIDTH);
	localparam logic [STEP_WIDTH-1:0] MOD_STEPS = STEP_WIDTH'(COUNT_WIDTH);

	typedef enum logic [1:0] {
		REG_STRIPE_BLOCKS = 2'd0,
		REG_STRIPE_COUNT  = 2'd1,
		REG_HOME_STRIPE   = 2'd2
	} reg_index_t;

	typedef enum logic {
		OP_SET = 1'b0,
		OP_ADD = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SPAN,
		S_DIV,
		S_MOD,
		S_LEAF,
		S_CLIMB,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                          opcode;
		logic [BLOCK_WIDTH-1:0]        block_number;
		logic signed [DIFF_WIDTH-1:0]  update_value;
	} in_item_t;

	typedef struct packed {
		logic                          applied;
		logic                          found;
		logic [BLOCK_WIDTH-1:0]        best_block;
		logic signed [DIFF_WIDTH-1:0]  best_diff;
	} out_item_t;

	typedef struct packed {
		logic                    start;
		logic [BLOCK_WIDTH-1:0]  dividend;
		logic [SPAN_WIDTH-1:0]   divisor;
		logic [STEP_WIDTH-1:0]   steps;
	} div_req_t;

endpackage

>>> rtl/ttmt_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on ttmt_pkg.
module ttmt_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ttmt_pkg::div_req_t                     req,
	output logic                                   busy,
	output logic [ttmt_pkg::BLOCK_WIDTH-1:0]       quotient,
	output logic [ttmt_pkg::SPAN_WIDTH-1:0]        remainder
);

	logic [ttmt_pkg::BLOCK_WIDTH-1:0] num_q;
	logic [ttmt_pkg::SPAN_WIDTH-1:0]  rem_q;
	logic [ttmt_pkg::SPAN_WIDTH-1:0]  div_q;
	logic [ttmt_pkg::STEP_WIDTH-1:0]  cnt_q;
	logic                             busy_q;
	logic [ttmt_pkg::SPAN_WIDTH:0]    trial;
	logic                             qbit;

	assign trial = {rem_q, num_q[ttmt_pkg::BLOCK_WIDTH-1]};
	assign qbit  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ttmt_pkg::STEP_WIDTH'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[ttmt_pkg::BLOCK_WIDTH-2:0], qbit};
			if (qbit) begin
				rem_q <= ttmt_pkg::SPAN_WIDTH'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[ttmt_pkg::SPAN_WIDTH-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

>>> rtl/ttmt_count_mem.sv
`timescale 1ns / 1ps
// Leaf count memory: one row per leaf pair, {free1, cached1, free0, cached0}.
// Depends on ttmt_pkg.
module ttmt_count_mem #(
	parameter int ROWS = ttmt_pkg::SLOT_COUNT_DEF / 2,
	parameter int AW   = 9
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic [ttmt_pkg::ROW_WIDTH-1:0]    wdata,
	input  logic [AW-1:0]                     raddr,
	output logic [ttmt_pkg::ROW_WIDTH-1:0]    rdata
);

	logic [ttmt_pkg::ROW_WIDTH-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ttmt_tree_mem.sv
`timescale 1ns / 1ps
// Tree node memory, one write port and two registered read ports.
// Depends on ttmt_pkg for default sizing only.
module ttmt_tree_mem #(
	parameter int DEPTH = ttmt_pkg::SLOT_COUNT_DEF,
	parameter int AW    = 10,
	parameter int DW    = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	output logic [DW-1:0] rdata_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/tournament_tree_max_tracker_core.sv
`timescale 1ns / 1ps
// Top level of the tournament tree max tracker.
// Depends on ttmt_pkg, ttmt_div, ttmt_count_mem and ttmt_tree_mem.
//
// Usage:
//  in_valid/in_ready/in_item carry update events; out_valid/out_ready/out_item
//  carry exactly one result per event. cfg_valid/cfg_ready/cfg_index/cfg_data
//  write blocks per stripe (0), stripe_count (1) and the home stripe (2);
//  cfg_ready is always high and writes are meant for idle periods only.
//  One event is worked at a time. An event goes through a step to form
//  the stripe span, the shared restoring divider for the slot, a second
//  divider pass for the slot modulo stripe_count, a read-modify-write of
//  the leaf pair row, one climb step per tree level (at most log2 of the
//  leaf count, stopping at the first parent that already holds the winner),
//  and a final step to form the result. An update that is ignored early
//  skips the later steps.
//  After reset the block sweeps both memories to zero, one entry a cycle
//  over the leaf count, with in_ready low.
//  A finished result waits in the output register; in_ready returns once it
//  is loaded, and a stalled receiver holds the next result in the final step.
module tournament_tree_max_tracker_core #(
	parameter int SLOT_COUNT = ttmt_pkg::SLOT_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ttmt_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ttmt_pkg::out_item_t   out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	localparam int LEAF = (SLOT_COUNT <= 2) ? 2 : 2 ** $clog2(SLOT_COUNT);
	localparam int LW   = $clog2(LEAF);
	localparam int RW   = (LW > 1) ? LW - 1 : 1;
	localparam int NW   = LW + ttmt_pkg::DIFF_WIDTH;
	localparam int DW   = ttmt_pkg::DIFF_WIDTH;
	localparam int BW   = ttmt_pkg::BLOCK_WIDTH;
	localparam int SW   = ttmt_pkg::SPAN_WIDTH;
	localparam int PW   = LW + SW;

	ttmt_pkg::state_t state_q, state_d;

	logic [ttmt_pkg::SIZE_WIDTH-1:0]  stripe_blocks_q;
	logic [ttmt_pkg::COUNT_WIDTH-1:0] stripe_count_q;
	logic [ttmt_pkg::COUNT_WIDTH-1:0] home_stripe_q;

	ttmt_pkg::in_item_t item_q;
	logic [SW-1:0]      span_q;
	logic [LW-1:0]      slot_q;
	logic               applied_q;
	logic [LW-1:0]      clr_q;
	logic [LW-1:0]      p_q;
	logic               first_q;
	logic               prev_left_q;
	logic [NW-1:0]      prev_q;
	logic [NW-1:0]      c0_q, c1_q;
	logic [NW-1:0]      root_q;
	logic               out_valid_q;
	ttmt_pkg::out_item_t out_q;

	// divider
	ttmt_pkg::div_req_t div_req;
	logic               div_busy;
	logic [BW-1:0]      div_quot;
	logic [SW-1:0]      div_rem;
	logic [SW-1:0]      span_w;

	// memories
	logic                         cnt_we;
	logic [RW-1:0]                cnt_waddr, cnt_raddr;
	logic [ttmt_pkg::ROW_WIDTH-1:0] cnt_wdata, cnt_rdata;
	logic                         tr_we;
	logic [LW-1:0]                tr_waddr, tr_raddr_a, tr_raddr_b;
	logic [NW-1:0]                tr_wdata, tr_rdata_a, tr_rdata_b;

	// leaf update
	logic [DW-1:0] f0_o, c0_o, f1_o, c1_o;
	logic [DW-1:0] f0_n, c0_n, f1_n, c1_n;
	logic [DW-1:0] upd_val;
	logic          leaf_apply;
	logic [ttmt_pkg::ROW_WIDTH-1:0] row_new;
	logic [LW-1:0] leaf_parent;

	// climb
	logic [NW-1:0] cl, cr, pick;
	logic          pick_right;
	logic          par_same;
	logic [LW-1:0] up_parent, sib;

	logic        in_take, quot_ok, mod_ok, out_load;
	logic [BW-1:0] best_w;

	assign span_w = SW'(stripe_blocks_q) * SW'(stripe_count_q);

	ttmt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.busy      (div_busy),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	ttmt_count_mem #(.ROWS(LEAF / 2), .AW(RW)) u_cnt_mem (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	ttmt_tree_mem #(.DEPTH(LEAF), .AW(LW), .DW(NW)) u_tree_mem (
		.clk     (clk),
		.we      (tr_we),
		.waddr   (tr_waddr),
		.wdata   (tr_wdata),
		.raddr_a (tr_raddr_a),
		.rdata_a (tr_rdata_a),
		.raddr_b (tr_raddr_b),
		.rdata_b (tr_rdata_b)
	);

	// leaf pair arithmetic
	assign upd_val = DW'(item_q.update_value);
	assign c0_o = cnt_rdata[DW-1:0];
	assign f0_o = cnt_rdata[2*DW-1:DW];
	assign c1_o = cnt_rdata[3*DW-1:2*DW];
	assign f1_o = cnt_rdata[4*DW-1:3*DW];

	always_comb begin
		f0_n = f0_o;
		c0_n = c0_o;
		f1_n = f1_o;
		c1_n = c1_o;
		leaf_apply = 1'b0;
		if (item_q.opcode == ttmt_pkg::OP_SET) begin
			if (slot_q[0]) begin
				leaf_apply = (f1_o != upd_val);
				f1_n = upd_val;
			end else begin
				leaf_apply = (f0_o != upd_val);
				f0_n = upd_val;
			end
		end else begin
			leaf_apply = (upd_val != '0);
			if (slot_q[0]) begin
				c1_n = DW'(c1_o + upd_val);
			end else begin
				c0_n = DW'(c0_o + upd_val);
			end
		end
	end

	assign row_new     = {f1_n, c1_n, f0_n, c0_n};
	assign leaf_parent = LW'(LEAF / 2 - 1) + LW'(slot_q >> 1);

	// tournament compare at one level
	always_comb begin
		if (first_q) begin
			cl = c0_q;
			cr = c1_q;
		end else if (prev_left_q) begin
			cl = prev_q;
			cr = tr_rdata_b;
		end else begin
			cl = tr_rdata_b;
			cr = prev_q;
		end
	end

	assign pick_right = ($signed(cr[DW-1:0]) > $signed(cl[DW-1:0])) ||
		((cr[DW-1:0] == cl[DW-1:0]) && (cr[NW-1:DW] < cl[NW-1:DW]));
	assign pick       = pick_right ? cr : cl;
	assign par_same   = (tr_rdata_a == pick);
	assign up_parent  = LW'((p_q - 1'b1) >> 1);
	assign sib        = p_q[0] ? LW'(p_q + 1'b1) : LW'(p_q - 1'b1);

	assign quot_ok = (div_quot < BW'(SLOT_COUNT));
	assign mod_ok  = (div_rem == SW'(home_stripe_q));
	assign in_take = in_valid && in_ready;
	assign out_load = !out_valid_q || out_ready;

	assign best_w = BW'(PW'(root_q[NW-1:DW]) * PW'(span_q)) + BW'(home_stripe_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttmt_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = item_q.block_number;
		div_req.divisor  = span_w;
		div_req.steps    = ttmt_pkg::DIV_STEPS;
		cnt_we           = 1'b0;
		cnt_waddr        = RW'(slot_q >> 1);
		cnt_wdata        = row_new;
		cnt_raddr        = RW'(div_quot >> 1);
		tr_we            = 1'b0;
		tr_waddr         = p_q;
		tr_wdata         = pick;
		tr_raddr_a       = up_parent;
		tr_raddr_b       = sib;
		case (state_q)
			ttmt_pkg::S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q[RW-1:0];
				cnt_wdata = '0;
				tr_we     = 1'b1;
				tr_waddr  = clr_q;
				tr_wdata  = '0;
				if (clr_q == LW'(LEAF - 1)) begin
					state_d = ttmt_pkg::S_IDLE;
				end
			end
			ttmt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ttmt_pkg::S_SPAN;
				end
			end
			ttmt_pkg::S_SPAN: begin
				if (span_w == '0) begin
					state_d = ttmt_pkg::S_DONE;
				end else begin
					div_req.start = 1'b1;
					state_d       = ttmt_pkg::S_DIV;
				end
			end
			ttmt_pkg::S_DIV: begin
				if (!div_busy) begin
					if (quot_ok) begin
						div_req.start    = 1'b1;
						div_req.dividend = {16'(div_quot), 32'd0};
						div_req.divisor  = SW'(stripe_count_q);
						div_req.steps    = ttmt_pkg::MOD_STEPS;
						state_d          = ttmt_pkg::S_MOD;
					end else begin
						state_d = ttmt_pkg::S_DONE;
					end
				end
			end
			ttmt_pkg::S_MOD: begin
				cnt_raddr = RW'(slot_q >> 1);
				if (!div_busy) begin
					state_d = mod_ok ? ttmt_pkg::S_LEAF : ttmt_pkg::S_DONE;
				end
			end
			ttmt_pkg::S_LEAF: begin
				tr_raddr_a = leaf_parent;
				if (leaf_apply) begin
					cnt_we  = 1'b1;
					state_d = ttmt_pkg::S_CLIMB;
				end else begin
					state_d = ttmt_pkg::S_DONE;
				end
			end
			ttmt_pkg::S_CLIMB: begin
				if (par_same) begin
					state_d = ttmt_pkg::S_DONE;
				end else begin
					tr_we = 1'b1;
					if (p_q == '0) begin
						state_d = ttmt_pkg::S_DONE;
					end
				end
			end
			ttmt_pkg::S_DONE: begin
				if (out_load) begin
					state_d = ttmt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ttmt_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stripe_blocks_q <= ttmt_pkg::SIZE_WIDTH'(1);
			stripe_count_q  <= ttmt_pkg::COUNT_WIDTH'(1);
			home_stripe_q   <= '0;
			clr_q           <= '0;
			root_q          <= '0;
			out_valid_q     <= 1'b0;
			applied_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ttmt_pkg::REG_STRIPE_BLOCKS: begin
						stripe_blocks_q <= cfg_data[ttmt_pkg::SIZE_WIDTH-1:0];
					end
					ttmt_pkg::REG_STRIPE_COUNT: begin
						stripe_count_q <= cfg_data;
					end
					ttmt_pkg::REG_HOME_STRIPE: begin
						home_stripe_q <= cfg_data;
					end
					default: ;
				endcase
			end
			if (state_q == ttmt_pkg::S_CLEAR) begin
				clr_q <= LW'(clr_q + 1'b1);
			end
			if (in_take) begin
				applied_q <= 1'b0;
			end
			if (state_q == ttmt_pkg::S_LEAF && leaf_apply) begin
				applied_q <= 1'b1;
			end
			if (tr_we && state_q == ttmt_pkg::S_CLIMB && p_q == '0) begin
				root_q <= pick;
			end
			if (state_q == ttmt_pkg::S_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q <= in_item;
		end
		if (state_q == ttmt_pkg::S_SPAN) begin
			span_q <= span_w;
		end
		if (state_q == ttmt_pkg::S_DIV) begin
			slot_q <= LW'(div_quot);
		end
		if (state_q == ttmt_pkg::S_LEAF) begin
			c0_q    <= {slot_q & ~LW'(1), DW'(f0_n - c0_n)};
			c1_q    <= {slot_q | LW'(1), DW'(f1_n - c1_n)};
			p_q     <= leaf_parent;
			first_q <= 1'b1;
		end
		if (state_q == ttmt_pkg::S_CLIMB) begin
			first_q     <= 1'b0;
			prev_q      <= pick;
			prev_left_q <= p_q[0];
			p_q         <= up_parent;
		end
		if (state_q == ttmt_pkg::S_DONE && out_load) begin
			out_q.applied   <= applied_q;
			out_q.found     <= ($signed(root_q[DW-1:0]) > 0);
			out_q.best_block <= ($signed(root_q[DW-1:0]) > 0) ? best_w : '0;
			out_q.best_diff <= $signed(root_q[DW-1:0]);
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
